// ===== hw/rtl/ewma_mean_stddev_tracker_assert.svh =====
// assertion macros for the ewma mean and deviation tracker
// expects clk and rst_n in the scope of the module that uses them
`ifndef EWMA_MEAN_STDDEV_TRACKER_ASSERT_SVH
`define EWMA_MEAN_STDDEV_TRACKER_ASSERT_SVH
`ifndef SYNTH
`define EMST_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define EMST_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define EMST_ASSERT_IMP(lbl, a, b, msg)
`define EMST_ASSERT_NXT(lbl, a, b, msg)
`endif
`endif

// ===== hw/rtl/emst_pkg.sv =====
// shared types and constants for the ewma mean and deviation tracker
// no dependencies
package emst_pkg;

  localparam logic [15:0] DECAY_RESET = 16'd64881;

  typedef struct packed {
    logic signed [31:0] mean_avg;
    logic [47:0]        square_avg;
    logic [31:0]        decay_power;
  } emst_state_t;

endpackage

// ===== hw/rtl/emst_if.sv =====
// valid/ready channel interfaces for sample, result and decay write
// no dependencies
interface emst_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface emst_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] corrected_mean;
  logic [15:0]        std_dev;
  logic [31:0]        samples_seen;
  modport source (output valid, output corrected_mean, output std_dev, output samples_seen,
                  input ready);
  modport sink (input valid, input corrected_mean, input std_dev, input samples_seen,
                output ready);
endinterface

interface emst_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] decay_factor;
  modport source (output valid, output decay_factor, input ready);
  modport sink (input valid, input decay_factor, output ready);
endinterface

// ===== hw/rtl/emst_update.sv =====
// bit-serial update of the moving averages, decay power and count
// depends on emst_pkg
module emst_update
  import emst_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [15:0]                   decay,
  output logic                          done,
  output emst_state_t                   st,
  output logic [COUNT_BITS-1:0]         count
);

  localparam int XW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam logic signed [XW-1:0] X_MAX = XW'(32767);
  localparam logic signed [XW-1:0] X_MIN = XW'(-32768);

  typedef enum logic [1:0] {U_IDLE, U_SQR, U_MUL, U_UPD} ustate_t;

  ustate_t                state_r;
  logic [4:0]             cnt_r;
  logic signed [15:0]     x_r;
  logic [31:0]            mc_r;
  logic [15:0]            mp_r;
  logic [31:0]            x2_r;
  logic [16:0]            dmul_r;
  logic [16:0]            amul_r;
  logic signed [48:0]     mean_sh_r;
  logic [63:0]            sq_sh_r;
  logic [47:0]            dp_sh_r;
  logic signed [33:0]     x_sh_r;
  logic [46:0]            x2_sh_r;
  logic signed [48:0]     acc_m_r;
  logic [63:0]            acc_s_r;
  logic [47:0]            acc_p_r;
  logic signed [33:0]     ax_r;
  logic [46:0]            ax2_r;
  emst_state_t            st_r;
  logic [COUNT_BITS-1:0]  count_r;

  logic signed [XW-1:0]   xe;
  logic signed [15:0]     xs;
  logic [15:0]            xa;
  logic [31:0]            x2_sum;
  logic signed [48:0]     m_rnd;
  logic signed [32:0]     m_sh;
  logic signed [34:0]     m_sum;
  logic [31:0]            m_new;
  logic [63:0]            s_rnd;
  logic [48:0]            s_sum;
  logic [47:0]            s_new;
  logic [47:0]            p_rnd;

  // clamp the sample to q7.8 and take its magnitude
  always_comb begin
    xe = XW'(sample);
    if (xe > X_MAX) begin
      xs = 16'sh7fff;
    end else if (xe < X_MIN) begin
      xs = 16'sh8000;
    end else begin
      xs = xe[15:0];
    end
    xa = xs[15] ? 16'(16'd0 - 16'(xs)) : 16'(xs);
  end

  assign x2_sum = mp_r[0] ? (x2_r + mc_r) : x2_r;

  always_comb begin
    m_rnd = acc_m_r + 49'sd32768;
    m_sh  = m_rnd[48:16];
    m_sum = 35'(m_sh) + 35'(ax_r);
    if (m_sum > 35'sd2147483647) begin
      m_new = 32'h7fff_ffff;
    end else if (m_sum < -35'sd2147483648) begin
      m_new = 32'h8000_0000;
    end else begin
      m_new = m_sum[31:0];
    end
    s_rnd = acc_s_r + 64'd32768;
    s_sum = {1'b0, s_rnd[63:16]} + 49'(ax2_r);
    s_new = s_sum[48] ? 48'hffff_ffff_ffff : s_sum[47:0];
    p_rnd = acc_p_r + 48'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= U_IDLE;
      cnt_r               <= '0;
      st_r.mean_avg       <= '0;
      st_r.square_avg     <= '0;
      st_r.decay_power    <= '1;
      count_r             <= '0;
    end else begin
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            x_r     <= xs;
            mc_r    <= {16'd0, xa};
            mp_r    <= xa;
            x2_r    <= '0;
            cnt_r   <= '0;
            state_r <= U_SQR;
          end
        end
        U_SQR: begin
          x2_r  <= x2_sum;
          mc_r  <= {mc_r[30:0], 1'b0};
          mp_r  <= {1'b0, mp_r[15:1]};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            dmul_r    <= {1'b0, decay};
            amul_r    <= 17'h10000 - {1'b0, decay};
            mean_sh_r <= 49'(st_r.mean_avg);
            sq_sh_r   <= 64'(st_r.square_avg);
            dp_sh_r   <= 48'(st_r.decay_power);
            x_sh_r    <= 34'(x_r);
            x2_sh_r   <= 47'(x2_sum);
            acc_m_r   <= '0;
            acc_s_r   <= '0;
            acc_p_r   <= '0;
            ax_r      <= '0;
            ax2_r     <= '0;
            cnt_r     <= '0;
            state_r   <= U_MUL;
          end
        end
        U_MUL: begin
          if (dmul_r[0]) begin
            acc_m_r <= acc_m_r + mean_sh_r;
            acc_s_r <= acc_s_r + sq_sh_r;
            acc_p_r <= acc_p_r + dp_sh_r;
          end
          if (amul_r[0]) begin
            ax_r  <= ax_r + x_sh_r;
            ax2_r <= ax2_r + x2_sh_r;
          end
          dmul_r    <= {1'b0, dmul_r[16:1]};
          amul_r    <= {1'b0, amul_r[16:1]};
          mean_sh_r <= {mean_sh_r[47:0], 1'b0};
          sq_sh_r   <= {sq_sh_r[62:0], 1'b0};
          dp_sh_r   <= {dp_sh_r[46:0], 1'b0};
          x_sh_r    <= {x_sh_r[32:0], 1'b0};
          x2_sh_r   <= {x2_sh_r[45:0], 1'b0};
          cnt_r     <= cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            state_r <= U_UPD;
          end
        end
        U_UPD: begin
          st_r.mean_avg    <= m_new;
          st_r.square_avg  <= s_new;
          st_r.decay_power <= p_rnd[47:16];
          if (count_r != '1) begin
            count_r <= count_r + COUNT_BITS'(1);
          end
          state_r <= U_IDLE;
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done  = (state_r == U_UPD);
  assign st    = st_r;
  assign count = count_r;

endmodule

// ===== hw/rtl/emst_div.sv =====
// restoring divider, one quotient bit per cycle, with overflow flag
// no dependencies
module emst_div #(
  parameter int DVD_W = 48,
  parameter int QUO_W = 16,
  parameter int DIV_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [QUO_W-1:0] quotient,
  output logic             ovf
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DIV_W-1:0] dsr_r;
  logic [DIV_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic             ovf_r;

  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   diff;
  logic             ge;

  always_comb begin
    r2   = {rem_r, dvd_r[DVD_W-1]};
    diff = r2 - {1'b0, dsr_r};
    ge   = (r2 >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      ovf_r <= ovf_r | quo_r[QUO_W-1];
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(DVD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
  assign ovf      = ovf_r;

endmodule

// ===== hw/rtl/emst_sqrt.sv =====
// digit-by-digit integer square root, two radicand bits per cycle
// no dependencies
module emst_sqrt #(
  parameter int IN_W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IN_W-1:0]   radicand,
  output logic              busy,
  output logic [IN_W/2-1:0] root
);

  localparam int RW = IN_W / 2;
  localparam int CW = $clog2(RW + 1);

  logic            busy_r;
  logic [CW-1:0]   cnt_r;
  logic [IN_W-1:0] val_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;

  logic [RW+3:0]   r2;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   diff;
  logic            ge;

  always_comb begin
    r2    = {rem_r, val_r[IN_W-1 -: 2]};
    trial = (RW+4)'({root_r, 2'b01});
    diff  = r2 - trial;
    ge    = (r2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      val_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[RW+1:0] : r2[RW+1:0];
      root_r <= {root_r[RW-2:0], ge};
      val_r  <= {val_r[IN_W-3:0], 2'b00};
      cnt_r  <= cnt_r + CW'(1);
      if (cnt_r == CW'(RW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/ewma_mean_stddev_tracker.sv =====
// ewma mean and deviation tracker: one sample at a time, a new sample is taken only after
// the previous result is registered; update (16 square, 17 multiply, 1 write), 80-step
// divide by the correction, 31 mean-square steps, 24 square-root steps; with a zero
// correction the divide, mean-square and square-root steps are skipped and both results are zero.
// a stalled result holds the last step. decay_factor resets to 64881, averages and count
// to zero, decay power to one. synchronous active-low reset, no clearing pass
`include "ewma_mean_stddev_tracker_assert.svh"
module ewma_mean_stddev_tracker
  import emst_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  emst_in_if.sink   in_smp,
  emst_out_if.source out_res,
  emst_cfg_if.sink  cfg_wr
);

  localparam int CNW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_PREP, S_DIV, S_MSQ, S_VAR, S_SQRT, S_FIN
  } state_t;

  state_t          state_r;
  logic [15:0]     decay_r;
  logic [4:0]      cnt_r;
  logic [61:0]     mc_r;
  logic [30:0]     mp_r;
  logic [61:0]     mu2_r;
  logic [62:0]     sec_r;
  logic [15:0]     mres_r;
  logic [15:0]     sres_r;
  logic            out_valid_r;
  logic [15:0]     om_r;
  logic [15:0]     os_r;
  logic [31:0]     oc_r;

  logic                  in_take;
  logic                  upd_done;
  emst_state_t           st;
  logic [COUNT_BITS-1:0] count;
  logic [CNW-1:0]        cnt_ext;
  logic [31:0]           cnt_sat;

  logic [31:0]  corr;
  logic [31:0]  mag;
  logic [47:0]  dvd_m;
  logic [55:0]  dvd_mu;
  logic [79:0]  dvd_s;
  logic         div_start;
  logic         div_m_busy, div_mu_busy, div_s_busy;
  logic         div_busy;
  logic [15:0]  q_m;
  logic [30:0]  q_mu;
  logic [61:0]  q_s;
  logic         ovf_m, ovf_mu, ovf_s;
  logic [15:0]  mean_fin;
  logic [30:0]  mu_fin;
  logic [62:0]  sec_fin;

  logic         sq_start;
  logic         sq_busy;
  logic [23:0]  sq_root;
  logic [62:0]  var_w;
  logic [61:0]  mu2_sum;

  assign in_take      = in_smp.valid && in_smp.ready;
  assign in_smp.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      decay_r <= cfg_wr.decay_factor;
    end
  end

  emst_update #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_take),
    .sample (in_smp.sample),
    .decay  (decay_r),
    .done   (upd_done),
    .st     (st),
    .count  (count)
  );

  always_comb begin
    corr    = ~st.decay_power;
    mag     = st.mean_avg[31] ? (~st.mean_avg + 32'd1) : st.mean_avg;
    dvd_m   = {mag, 16'd0} + 48'(corr[31:1]);
    dvd_mu  = {mag, 24'd0} + 56'(corr[31:1]);
    dvd_s   = {st.square_avg, 32'd0};
    cnt_ext = CNW'(count);
    cnt_sat = (cnt_ext > CNW'(32'hffff_ffff)) ? 32'hffff_ffff : cnt_ext[31:0];
  end

  assign div_start = (state_r == S_PREP) && (corr != 32'd0);
  assign div_busy  = div_m_busy || div_mu_busy || div_s_busy;

  emst_div #(.DVD_W(48), .QUO_W(16), .DIV_W(32)) u_div_mean (
    .clk (clk), .rst_n (rst_n), .start (div_start), .dividend (dvd_m), .divisor (corr),
    .busy (div_m_busy), .quotient (q_m), .ovf (ovf_m)
  );

  emst_div #(.DVD_W(56), .QUO_W(31), .DIV_W(32)) u_div_mu (
    .clk (clk), .rst_n (rst_n), .start (div_start), .dividend (dvd_mu), .divisor (corr),
    .busy (div_mu_busy), .quotient (q_mu), .ovf (ovf_mu)
  );

  emst_div #(.DVD_W(80), .QUO_W(62), .DIV_W(32)) u_div_sq (
    .clk (clk), .rst_n (rst_n), .start (div_start), .dividend (dvd_s), .divisor (corr),
    .busy (div_s_busy), .quotient (q_s), .ovf (ovf_s)
  );

  // rounded mean with sign, clamped to q7.8
  always_comb begin
    if (st.mean_avg[31]) begin
      mean_fin = (ovf_m || (q_m > 16'h8000)) ? 16'h8000 : 16'(16'd0 - q_m);
    end else begin
      mean_fin = (ovf_m || q_m[15]) ? 16'h7fff : q_m;
    end
    mu_fin  = ovf_mu ? 31'h7fff_ffff : q_mu;
    sec_fin = ovf_s ? {1'b1, 62'd0} : {1'b0, q_s};
    mu2_sum = mp_r[0] ? (mu2_r + mc_r) : mu2_r;
    var_w   = (sec_r > {1'b0, mu2_r}) ? (sec_r - {1'b0, mu2_r}) : 63'd0;
  end

  assign sq_start = (state_r == S_VAR);

  emst_sqrt #(.IN_W(48)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (48'(var_w[62:16])),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && (!out_valid_r || out_res.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_done) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          if (corr == 32'd0) begin
            mres_r  <= '0;
            sres_r  <= '0;
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            mres_r  <= mean_fin;
            sec_r   <= sec_fin;
            mc_r    <= 62'(mu_fin);
            mp_r    <= mu_fin;
            mu2_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MSQ;
          end
        end
        S_MSQ: begin
          mu2_r <= mu2_sum;
          mc_r  <= {mc_r[60:0], 1'b0};
          mp_r  <= {1'b0, mp_r[30:1]};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd30) begin
            state_r <= S_VAR;
          end
        end
        S_VAR: begin
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (!sq_busy) begin
            sres_r  <= (sq_root[23:16] != 8'd0) ? 16'hffff : sq_root[15:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_res.ready) begin
            om_r    <= mres_r;
            os_r    <= sres_r;
            oc_r    <= cnt_sat;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.corrected_mean = om_r;
  assign out_res.std_dev        = os_r;
  assign out_res.samples_seen   = oc_r;

  `EMST_ASSERT_NXT(a_take_starts_update, in_take, state_r == S_UPD, "transfer without update")
  `EMST_ASSERT_IMP(a_update_done_in_wait, upd_done, state_r == S_UPD, "update done out of wait")
  `EMST_ASSERT_IMP(a_div_busy_in_div, div_busy, state_r == S_DIV, "divider busy out of state")
  `EMST_ASSERT_IMP(a_sqrt_busy_in_sqrt, sq_busy, state_r == S_SQRT, "root busy out of state")

endmodule

// ===== tb/testbench.sv =====
// self-checking bench for the ewma mean and deviation tracker: samples, results, decay writes
// depends on emst_pkg, the emst_*_if interfaces and ewma_mean_stddev_tracker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import emst_pkg::*;

  localparam int          WATCHDOG_LIMIT = 20000;
  localparam bit [63:0]   ONE_Q32        = 64'hFFFF_FFFF;
  localparam bit [63:0]   COUNT_MAX      = 64'hFFFF_FFFF;

  typedef struct {
    logic signed [15:0] mean;
    logic [15:0]        dev;
    logic [31:0]        seen;
  } stats_t;

  logic clk;
  logic rst_n;

  emst_in_if #(.SAMPLE_BITS(16)) in_smp ();
  emst_out_if                    out_res ();
  emst_cfg_if                    cfg_wr ();

  ewma_mean_stddev_tracker #(.SAMPLE_BITS(16), .COUNT_BITS(32)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_smp  (in_smp.sink),
    .out_res (out_res.source),
    .cfg_wr  (cfg_wr.sink)
  );

  // tracker state mirror
  longint     avg_mean;
  bit [63:0]  avg_square;
  bit [63:0]  decay_pow;
  bit [63:0]  sample_count;
  bit [15:0]  decay_cur;

  stats_t     stats_q[$];
  int         errors;
  int         samples_sent;
  int         results_checked;
  int         decay_writes;
  int         burst_left;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic stats_t predict_stats(logic signed [15:0] x);
    stats_t    r;
    longint    xs, d, alpha, acc;
    bit [63:0] du, au, sq, c, mag, m, q1, second, mu, variance, root;
    bit        neg;
    xs = x;
    d = longint'(decay_cur);
    alpha = 65536 - d;
    acc = d * avg_mean + alpha * xs * 65536 + 32768;
    acc = acc >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    avg_mean = acc;
    du = 64'(d);
    au = 64'(alpha);
    sq = 64'(xs * xs);
    avg_square = (du * avg_square + au * sq * 64'd65536 + 64'd32768) >> 16;
    decay_pow = (decay_pow * du + 64'd32768) >> 16;
    if (sample_count < COUNT_MAX) sample_count++;
    r.mean = '0;
    r.dev = '0;
    r.seen = sample_count[31:0];
    c = ONE_Q32 - decay_pow;
    if (c != 0) begin
      neg = avg_mean < 0;
      mag = neg ? 64'(-avg_mean) : 64'(avg_mean);
      m = ((mag << 16) + (c >> 1)) / c;
      if (neg) begin
        if (m > 64'd32768) m = 64'd32768;
        r.mean = 16'(-m);
      end else begin
        if (m > 64'd32767) m = 64'd32767;
        r.mean = m[15:0];
      end
      q1 = avg_square / c;
      if (q1 >= (64'd1 << 30)) second = 64'd1 << 62;
      else second = (q1 << 32) + ((avg_square % c) << 32) / c;
      mu = ((mag << 24) + (c >> 1)) / c;
      if (mu > 64'h7FFF_FFFF) mu = 64'h7FFF_FFFF;
      variance = mu * mu;
      variance = second > variance ? second - variance : 64'd0;
      root = root_floor(variance >> 16);
      if (root > 64'd65535) root = 64'd65535;
      r.dev = root[15:0];
    end
    return r;
  endfunction

  // sample sender: bursts of random length with random gaps
  task automatic send_sample(logic signed [15:0] x);
    if (burst_left == 0) begin
      in_smp.valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_smp.valid <= 1'b1;
    in_smp.sample <= x;
    do @(posedge clk); while (!in_smp.ready);
    stats_q = {stats_q, predict_stats(x)};
    samples_sent++;
  endtask

  task automatic drain();
    in_smp.valid <= 1'b0;
    burst_left = 0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_decay(bit [15:0] v);
    drain();
    cfg_wr.valid <= 1'b1;
    cfg_wr.decay_factor <= v;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    decay_cur = v;
    decay_writes++;
  endtask

  function automatic logic signed [15:0] random_sample(int level, int spread);
    int v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: v = $urandom_range(0, 65535) - 32768;
      5:             v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default:       v = level + $urandom_range(0, 2 * spread) - spread;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic test_directed();
    logic signed [15:0] pts[$];
    pts = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sd256, -16'sd256,
            16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA,
            16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  task automatic test_decay_extremes();
    write_decay(16'd0);
    repeat (6) send_sample(16'sh7FFF);
    repeat (6) send_sample(16'sh8000);
    write_decay(16'hFFFF);
    repeat (8) send_sample(random_sample(0, 32767));
    write_decay(16'd32768);
    repeat (6) send_sample(random_sample(-20000, 100));
  endtask

  task automatic test_random_streams(int total);
    int level, spread, n;
    bit [15:0] d;
    while (total > 0) begin
      case ($urandom_range(0, 5))
        0:       d = 16'd0;
        1:       d = 16'hFFFF;
        2:       d = DECAY_RESET;
        default: d = 16'($urandom_range(60000, 65535));
      endcase
      if ($urandom_range(0, 4) == 0) d = 16'($urandom_range(0, 65535));
      write_decay(d);
      n = $urandom_range(40, 160);
      if (n > total) n = total;
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) begin
          level = $urandom_range(0, 65535) - 32768;
          spread = 1 << $urandom_range(0, 15);
        end
        send_sample(random_sample(level, spread));
      end
      total -= n;
    end
  endtask

  // result receiver with its own stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else if (($urandom_range(0, 255) < 128) && (samples_sent % 200 < 120)) begin
      out_res.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_res.valid && out_res.ready) begin
      results_checked++;
      if (stats_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = stats_q.pop_front();
        if (out_res.corrected_mean !== e.mean) begin
          $error("corrected_mean expected %0d actual %0d", e.mean, out_res.corrected_mean);
          errors++;
        end
        if (out_res.std_dev !== e.dev) begin
          $error("std_dev expected %0d actual %0d", e.dev, out_res.std_dev);
          errors++;
        end
        if (out_res.samples_seen !== e.seen) begin
          $error("samples_seen expected %0d actual %0d", e.seen, out_res.samples_seen);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_smp.valid && in_smp.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    samples_sent = 0;
    results_checked = 0;
    decay_writes = 0;
    burst_left = 0;
    idle_cycles = 0;
    avg_mean = 0;
    avg_square = 0;
    decay_pow = ONE_Q32;
    sample_count = 0;
    decay_cur = DECAY_RESET;
    rst_n = 1'b0;
    in_smp.valid = 1'b0;
    in_smp.sample = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.decay_factor = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_decay_extremes();
    test_random_streams(1400);
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d samples, %0d results checked, %0d decay writes",
             samples_sent, results_checked, decay_writes);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// ===== ewma_mean_stddev_tracker.f =====
+incdir+hw/rtl
hw/rtl/emst_pkg.sv
hw/rtl/emst_if.sv
hw/rtl/emst_update.sv
hw/rtl/emst_div.sv
hw/rtl/emst_sqrt.sv
hw/rtl/ewma_mean_stddev_tracker.sv
tb/testbench.sv
